/* rtl/plm_pkg.sv */
`timescale 1ns / 1ps
// plm_pkg: shared types and constants for the positional list engine.
// Used by plm_cell and positional_list_engine; depends on nothing.
package plm_pkg;

    localparam int LIST_CAP_DEF = 64;
    // Wide enough for any cell index within the supported capacity range
    localparam int TGT_W        = 10;
    localparam int MODE_W       = 3;
    localparam int POS_W        = 7;
    localparam int DATA_W       = 32;
    localparam int STATUS_W     = 2;
    localparam int LEN_W        = 7;

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND    = 3'd0,
        MODE_READ      = 3'd1,
        MODE_INSERT    = 3'd2,
        MODE_DELETE    = 3'd3,
        MODE_OVERWRITE = 3'd4
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        CELL_NONE,
        CELL_WRITE,
        CELL_INSERT,
        CELL_DELETE,
        CELL_CAPTURE
    } t_cell_op;

    typedef enum logic {
        S_IDLE,
        S_WALK
    } t_state;

    typedef struct packed {
        t_mode                     mode;
        logic [POS_W-1:0]          position;
        logic signed [DATA_W-1:0]  value;
    } t_req;

    typedef struct packed {
        t_status                   status;
        logic signed [DATA_W-1:0]  read_value;
        logic [LEN_W-1:0]          length;
    } t_rsp;

    // Broadcast to every cell in the row
    typedef struct packed {
        t_cell_op                  op;
        logic [TGT_W-1:0]          tgt;
        logic [DATA_W-1:0]         value;
    } t_cell_cmd;

endpackage

/* rtl/plm_cell.sv */
`timescale 1ns / 1ps
// plm_cell: one list slot. Holds an entry and one stage of the read-out chain.
// Depends on plm_pkg.
module plm_cell #(
    parameter int IDX = 0
) (
    input  logic                      i_clk,
    input  plm_pkg::t_cell_cmd        i_cmd,
    input  logic [plm_pkg::DATA_W-1:0] i_left,
    input  logic [plm_pkg::DATA_W-1:0] i_right,
    input  logic [plm_pkg::DATA_W-1:0] i_carry_right,
    output logic [plm_pkg::DATA_W-1:0] o_data,
    output logic [plm_pkg::DATA_W-1:0] o_carry
);

    localparam logic [plm_pkg::TGT_W-1:0] MY_IDX = plm_pkg::TGT_W'(IDX);

    logic [plm_pkg::DATA_W-1:0] r_data;
    logic [plm_pkg::DATA_W-1:0] n_data;
    logic [plm_pkg::DATA_W-1:0] r_carry;
    logic [plm_pkg::DATA_W-1:0] n_carry;
    logic                       w_hit;
    logic                       w_above;

    assign w_hit   = (i_cmd.tgt == MY_IDX);
    assign w_above = (MY_IDX > i_cmd.tgt);

    always_comb begin
        n_data  = r_data;
        n_carry = i_carry_right;
        case (i_cmd.op)
            plm_pkg::CELL_WRITE: begin
                if (w_hit) n_data = i_cmd.value;
            end
            plm_pkg::CELL_INSERT: begin
                if (w_hit) n_data = i_cmd.value;
                else if (w_above) n_data = i_left;
            end
            plm_pkg::CELL_DELETE: begin
                if (w_hit || w_above) n_data = i_right;
                if (w_hit) n_carry = r_data;
            end
            plm_pkg::CELL_CAPTURE: begin
                if (w_hit) n_carry = r_data;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data  <= n_data;
        r_carry <= n_carry;
    end

    assign o_data  = r_data;
    assign o_carry = r_carry;

endmodule

/* rtl/positional_list_engine.sv */
`timescale 1ns / 1ps
// positional_list_engine: ordered list of signed words held in a row of cells.
// Depends on plm_pkg and plm_cell.

// A request is taken when start is high and busy is low; its result appears on
// o_rsp for one cycle with o_done high, and must be taken then. Append, insert,
// overwrite and any rejected request finish without a walk: o_done rises the
// cycle after acceptance and a new request may be taken in that same cycle.
// Read and delete hand the selected word down the cell row one cell per cycle
// toward the output, so o_done rises once the word reaches cell 0, and busy is
// high while it moves. Entries hold no reset value; the length count resets to
// zero.
module positional_list_engine #(
    parameter int LIST_CAP = plm_pkg::LIST_CAP_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  plm_pkg::t_req i_req,
    output logic          busy,
    output logic          o_done,
    output plm_pkg::t_rsp o_rsp
);

    localparam int CW = $clog2(LIST_CAP + 1);
    localparam int IW = $clog2(LIST_CAP);
    localparam int W  = ((CW > plm_pkg::POS_W) ? CW : plm_pkg::POS_W) + 1;
    localparam logic [W-1:0] CAP_W = W'(LIST_CAP);

    plm_pkg::t_state     r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [IW-1:0]       r_walk, n_walk;
    logic                r_done, n_done;
    plm_pkg::t_rsp       r_rsp, n_rsp;
    plm_pkg::t_cell_cmd  w_cmd;

    logic [plm_pkg::DATA_W-1:0] w_data  [LIST_CAP];
    logic [plm_pkg::DATA_W-1:0] w_carry [LIST_CAP];

    logic          w_accept;
    logic [W-1:0]  w_pos, w_cnt, w_idx;
    logic          w_in_list, w_ins_ok, w_full;

    assign w_accept  = start && (r_state == plm_pkg::S_IDLE);
    assign w_pos     = W'(i_req.position);
    assign w_cnt     = W'(r_count);
    assign w_idx     = w_pos - W'(1);
    assign w_in_list = (w_pos != '0) && (w_pos <= w_cnt);
    assign w_ins_ok  = (w_pos != '0) && (w_pos <= w_cnt + W'(1));
    assign w_full    = (w_cnt == CAP_W);

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_walk  = r_walk;
        n_done  = 1'b0;
        n_rsp   = r_rsp;
        w_cmd.op    = plm_pkg::CELL_NONE;
        w_cmd.tgt   = plm_pkg::TGT_W'(w_idx[IW-1:0]);
        w_cmd.value = i_req.value;
        case (r_state)
            plm_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_rsp.status     = plm_pkg::ST_OK;
                    n_rsp.read_value = '0;
                    n_done           = 1'b1;
                    case (i_req.mode)
                        plm_pkg::MODE_APPEND: begin
                            if (w_full) begin
                                n_rsp.status = plm_pkg::ST_FULL;
                            end else begin
                                w_cmd.op  = plm_pkg::CELL_WRITE;
                                w_cmd.tgt = plm_pkg::TGT_W'(r_count[IW-1:0]);
                                n_count   = r_count + CW'(1);
                            end
                        end
                        plm_pkg::MODE_READ: begin
                            if (!w_in_list) begin
                                n_rsp.status = plm_pkg::ST_BADPOS;
                            end else begin
                                w_cmd.op = plm_pkg::CELL_CAPTURE;
                                n_walk   = w_idx[IW-1:0];
                                n_done   = 1'b0;
                                n_state  = plm_pkg::S_WALK;
                            end
                        end
                        plm_pkg::MODE_INSERT: begin
                            if (!w_ins_ok) begin
                                n_rsp.status = plm_pkg::ST_BADPOS;
                            end else if (w_full) begin
                                n_rsp.status = plm_pkg::ST_FULL;
                            end else begin
                                w_cmd.op = plm_pkg::CELL_INSERT;
                                n_count  = r_count + CW'(1);
                            end
                        end
                        plm_pkg::MODE_DELETE: begin
                            if (!w_in_list) begin
                                n_rsp.status = plm_pkg::ST_BADPOS;
                            end else begin
                                w_cmd.op = plm_pkg::CELL_DELETE;
                                n_count  = r_count - CW'(1);
                                n_walk   = w_idx[IW-1:0];
                                n_done   = 1'b0;
                                n_state  = plm_pkg::S_WALK;
                            end
                        end
                        plm_pkg::MODE_OVERWRITE: begin
                            if (!w_in_list) begin
                                n_rsp.status = plm_pkg::ST_BADPOS;
                            end else begin
                                w_cmd.op = plm_pkg::CELL_WRITE;
                            end
                        end
                        default: begin
                            n_rsp.status = plm_pkg::ST_BADPOS;
                        end
                    endcase
                    n_rsp.length = plm_pkg::LEN_W'(n_count);
                end
            end
            plm_pkg::S_WALK: begin
                // captured word moves one cell toward cell 0 per cycle
                if (r_walk == '0) begin
                    n_rsp.read_value = w_carry[0];
                    n_done           = 1'b1;
                    n_state          = plm_pkg::S_IDLE;
                end else begin
                    n_walk = r_walk - IW'(1);
                end
            end
            default: begin
                n_state = plm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= plm_pkg::S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_walk <= n_walk;
        r_rsp  <= n_rsp;
    end

    genvar gi;
    generate
        for (gi = 0; gi < LIST_CAP; gi++) begin : g_cell
            logic [plm_pkg::DATA_W-1:0] w_left, w_right, w_cright;
            if (gi == 0) begin : g_first
                assign w_left = '0;
            end else begin : g_mid_l
                assign w_left = w_data[gi-1];
            end
            if (gi == LIST_CAP - 1) begin : g_last
                assign w_right  = '0;
                assign w_cright = '0;
            end else begin : g_mid_r
                assign w_right  = w_data[gi+1];
                assign w_cright = w_carry[gi+1];
            end
            plm_cell #(
                .IDX (gi)
            ) u_cell (
                .i_clk         (i_clk),
                .i_cmd         (w_cmd),
                .i_left        (w_left),
                .i_right       (w_right),
                .i_carry_right (w_cright),
                .o_data        (w_data[gi]),
                .o_carry       (w_carry[gi])
            );
        end
    endgenerate

    assign busy   = (r_state == plm_pkg::S_WALK);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

/* dv/positional_list_engine_test.sv */
`timescale 1ns / 1ps
// positional_list_engine_test: self-checking bench for the positional list engine.
// Directed table then biased random requests, each checked against the table or a local list model.
// Depends on plm_pkg and positional_list_engine.
module positional_list_engine_test;

    localparam int LIST_CAP   = plm_pkg::LIST_CAP_DEF;
    localparam int N_RANDOM   = 2000;
    localparam int QUIET_TAIL = 300;
    localparam int CYCLE_CAP  = 1000000;
    localparam int N_PLAN     = 25;

    typedef struct packed {
        plm_pkg::t_mode                mode;
        logic [plm_pkg::POS_W-1:0]     pos;
        logic [plm_pkg::DATA_W-1:0]    val;
        logic                          typed;
        plm_pkg::t_status              st;
        logic [plm_pkg::DATA_W-1:0]    rd;
        logic [plm_pkg::LEN_W-1:0]     len;
    } t_row;

    typedef enum int {
        PH_GROW,
        PH_MIX,
        PH_SHRINK
    } t_phase;

    logic           i_clk;
    logic           i_rst_n;
    logic           start;
    plm_pkg::t_req  i_req;
    logic           busy;
    logic           o_done;
    plm_pkg::t_rsp  o_rsp;

    // local copy of the list
    logic [plm_pkg::DATA_W-1:0] list_mem [LIST_CAP];
    int                         list_len;

    plm_pkg::t_rsp  pending_rsp [$];
    int             error_count;
    int             cycle_cnt;
    t_row           plan [N_PLAN];

    positional_list_engine #(
        .LIST_CAP (LIST_CAP)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    initial begin
        wait (cycle_cnt >= CYCLE_CAP);
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic report_mismatch(input string what,
                                   input logic [plm_pkg::DATA_W-1:0] got,
                                   input logic [plm_pkg::DATA_W-1:0] want);
        $display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
        error_count++;
    endtask

    // Applies one request to the local list and returns the expected response.
    function automatic plm_pkg::t_rsp model_request(input plm_pkg::t_req rq);
        plm_pkg::t_rsp r;
        int            p;
        r.status     = plm_pkg::ST_OK;
        r.read_value = '0;
        p            = int'(rq.position);
        case (rq.mode)
            plm_pkg::MODE_APPEND: begin
                if (list_len >= LIST_CAP) begin
                    r.status = plm_pkg::ST_FULL;
                end else begin
                    list_mem[list_len] = rq.value;
                    list_len++;
                end
            end
            plm_pkg::MODE_READ: begin
                if (p < 1 || p > list_len) r.status = plm_pkg::ST_BADPOS;
                else r.read_value = list_mem[p-1];
            end
            plm_pkg::MODE_INSERT: begin
                // position check wins over the full check
                if (p < 1 || p > list_len + 1) begin
                    r.status = plm_pkg::ST_BADPOS;
                end else if (list_len >= LIST_CAP) begin
                    r.status = plm_pkg::ST_FULL;
                end else begin
                    for (int i = list_len; i >= p; i--) list_mem[i] = list_mem[i-1];
                    list_mem[p-1] = rq.value;
                    list_len++;
                end
            end
            plm_pkg::MODE_DELETE: begin
                if (p < 1 || p > list_len) begin
                    r.status = plm_pkg::ST_BADPOS;
                end else begin
                    r.read_value = list_mem[p-1];
                    for (int i = p - 1; i < list_len - 1; i++) list_mem[i] = list_mem[i+1];
                    list_len--;
                end
            end
            plm_pkg::MODE_OVERWRITE: begin
                if (p < 1 || p > list_len) r.status = plm_pkg::ST_BADPOS;
                else list_mem[p-1] = rq.value;
            end
            default: r.status = plm_pkg::ST_BADPOS;
        endcase
        r.length = plm_pkg::LEN_W'(list_len);
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_req(input plm_pkg::t_req rq, input int idle, input logic typed,
                            input plm_pkg::t_rsp typed_rsp);
        plm_pkg::t_rsp want;
        if (idle > 0) begin
            start <= 1'b0;
            repeat (idle) @(negedge i_clk);
        end
        start <= 1'b1;
        i_req <= rq;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        want = model_request(rq);
        if (typed) want = typed_rsp;
        pending_rsp.push_back(want);
        @(negedge i_clk);
    endtask

    function automatic plm_pkg::t_mode pick_mode(input t_phase ph);
        int r;
        int a, b, c, d, e;
        r = $urandom_range(0, 99);
        case (ph)
            PH_GROW:   begin a = 45; b = 70; c = 80; d = 88; e = 96; end
            PH_SHRINK: begin a = 10; b = 20; c = 35; d = 45; e = 96; end
            default:   begin a = 20; b = 40; c = 60; d = 75; e = 96; end
        endcase
        if (r < a) return plm_pkg::MODE_APPEND;
        if (r < b) return plm_pkg::MODE_INSERT;
        if (r < c) return plm_pkg::MODE_READ;
        if (r < d) return plm_pkg::MODE_OVERWRITE;
        if (r < e) return plm_pkg::MODE_DELETE;
        return plm_pkg::t_mode'(3'($urandom_range(5, 7)));
    endfunction

    // Response checker: the receiver cannot stall, so every strobe is a transaction.
    always @(posedge i_clk) begin
        plm_pkg::t_rsp want;
        if (i_rst_n && o_done) begin
            if (pending_rsp.size() == 0) begin
                report_mismatch("unexpected response",
                                plm_pkg::DATA_W'(o_rsp.read_value), '0);
            end else begin
                want = pending_rsp.pop_front();
                if (o_rsp.status !== want.status)
                    report_mismatch("status", plm_pkg::DATA_W'(o_rsp.status),
                                    plm_pkg::DATA_W'(want.status));
                if (o_rsp.read_value !== want.read_value)
                    report_mismatch("read_value", o_rsp.read_value, want.read_value);
                if (o_rsp.length !== want.length)
                    report_mismatch("length", plm_pkg::DATA_W'(o_rsp.length),
                                    plm_pkg::DATA_W'(want.length));
            end
        end
    end

    initial begin
        plm_pkg::t_req  rq;
        plm_pkg::t_rsp  typed_rsp;
        t_phase         ph;
        int             lim;
        int             sel;
        int             idle;

        i_rst_n  = 1'b0;
        start    = 1'b0;
        i_req    = '0;
        list_len = 0;

        plan = '{
            // empty list: positional requests are rejected, except insert at position 1
            '{plm_pkg::MODE_READ, 7'd1, 32'h0, 1'b1, plm_pkg::ST_BADPOS, 32'h0, 7'd0},
            '{plm_pkg::MODE_DELETE, 7'd1, 32'h0, 1'b1, plm_pkg::ST_BADPOS, 32'h0, 7'd0},
            '{plm_pkg::MODE_OVERWRITE, 7'd1, 32'h1234_5678, 1'b1, plm_pkg::ST_BADPOS, 32'h0, 7'd0},
            '{plm_pkg::MODE_INSERT, 7'd0, 32'h1234_5678, 1'b1, plm_pkg::ST_BADPOS, 32'h0, 7'd0},
            '{plm_pkg::MODE_INSERT, 7'd2, 32'h1234_5678, 1'b1, plm_pkg::ST_BADPOS, 32'h0, 7'd0},
            '{plm_pkg::MODE_INSERT, 7'd1, 32'h8000_0000, 1'b1, plm_pkg::ST_OK, 32'h0, 7'd1},
            // append ignores the position field
            '{plm_pkg::MODE_APPEND, 7'd127, 32'h7FFF_FFFF, 1'b1, plm_pkg::ST_OK, 32'h0, 7'd2},
            '{plm_pkg::MODE_APPEND, 7'd0, 32'h0, 1'b1, plm_pkg::ST_OK, 32'h0, 7'd3},
            '{plm_pkg::MODE_INSERT, 7'd4, 32'hFFFF_FFFF, 1'b1, plm_pkg::ST_OK, 32'h0, 7'd4},
            '{plm_pkg::MODE_INSERT, 7'd6, 32'h1, 1'b1, plm_pkg::ST_BADPOS, 32'h0, 7'd4},
            '{plm_pkg::MODE_READ, 7'd1, 32'h0, 1'b1, plm_pkg::ST_OK, 32'h8000_0000, 7'd4},
            '{plm_pkg::MODE_READ, 7'd4, 32'h0, 1'b1, plm_pkg::ST_OK, 32'hFFFF_FFFF, 7'd4},
            '{plm_pkg::MODE_READ, 7'd5, 32'h0, 1'b1, plm_pkg::ST_BADPOS, 32'h0, 7'd4},
            '{plm_pkg::MODE_READ, 7'd0, 32'h0, 1'b1, plm_pkg::ST_BADPOS, 32'h0, 7'd4},
            '{plm_pkg::MODE_READ, 7'd127, 32'h0, 1'b1, plm_pkg::ST_BADPOS, 32'h0, 7'd4},
            '{plm_pkg::MODE_OVERWRITE, 7'd2, 32'h5555_5555, 1'b0, plm_pkg::ST_OK, 32'h0, 7'd0},
            '{plm_pkg::MODE_OVERWRITE, 7'd5, 32'hAAAA_AAAA, 1'b1, plm_pkg::ST_BADPOS, 32'h0, 7'd4},
            '{plm_pkg::t_mode'(3'd5), 7'd1, 32'h0, 1'b1, plm_pkg::ST_BADPOS, 32'h0, 7'd4},
            '{plm_pkg::t_mode'(3'd7), 7'd127, 32'hAAAA_AAAA, 1'b1, plm_pkg::ST_BADPOS, 32'h0, 7'd4},
            '{plm_pkg::MODE_DELETE, 7'd5, 32'h0, 1'b1, plm_pkg::ST_BADPOS, 32'h0, 7'd4},
            '{plm_pkg::MODE_DELETE, 7'd2, 32'h0, 1'b0, plm_pkg::ST_OK, 32'h0, 7'd0},
            '{plm_pkg::MODE_READ, 7'd2, 32'h0, 1'b0, plm_pkg::ST_OK, 32'h0, 7'd0},
            '{plm_pkg::MODE_DELETE, 7'd3, 32'h0, 1'b0, plm_pkg::ST_OK, 32'h0, 7'd0},
            '{plm_pkg::MODE_DELETE, 7'd1, 32'h0, 1'b0, plm_pkg::ST_OK, 32'h0, 7'd0},
            '{plm_pkg::MODE_DELETE, 7'd1, 32'h0, 1'b0, plm_pkg::ST_OK, 32'h0, 7'd0}
        };

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < N_PLAN; i++) begin
            rq.mode              = plan[i].mode;
            rq.position          = plan[i].pos;
            rq.value             = plan[i].val;
            typed_rsp.status     = plan[i].st;
            typed_rsp.read_value = plan[i].rd;
            typed_rsp.length     = plan[i].len;
            idle = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
            send_req(rq, idle, plan[i].typed, typed_rsp);
        end

        // grow / mix / shrink phases so the list fills and drains repeatedly
        for (int k = 0; k < N_RANDOM; k++) begin
            if (k == N_RANDOM / 2) begin
                start <= 1'b0;
                @(negedge i_clk);
                while (pending_rsp.size() != 0) @(negedge i_clk);
            end
            ph = t_phase'((k / 200) % 3);
            rq.mode = pick_mode(ph);
            lim = (rq.mode == plm_pkg::MODE_INSERT) ? list_len + 1 : list_len;
            if (lim < 1) lim = 1;
            sel = $urandom_range(0, 9);
            if (sel == 0) rq.position = '0;
            else if (sel == 1) rq.position = plm_pkg::POS_W'($urandom_range(0, 127));
            else rq.position = plm_pkg::POS_W'($urandom_range(1, lim));
            case ($urandom_range(0, 15))
                0:       rq.value = 32'h8000_0000;
                1:       rq.value = 32'h7FFF_FFFF;
                2:       rq.value = 32'h0000_0000;
                3:       rq.value = 32'hFFFF_FFFF;
                default: rq.value = $urandom;
            endcase
            idle = 0;
            if (k < N_RANDOM - QUIET_TAIL && $urandom_range(0, 5) == 0)
                idle = $urandom_range(1, 4);
            send_req(rq, idle, 1'b0, '0);
        end

        start <= 1'b0;
        while (pending_rsp.size() != 0) @(negedge i_clk);
        repeat (LIST_CAP + 8) @(posedge i_clk);

        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* positional_list_engine.f */
rtl/plm_pkg.sv
rtl/plm_cell.sv
rtl/positional_list_engine.sv
dv/positional_list_engine_test.sv
